// ===== sv/bilinear_2x_upscaler_assert.svh =====
// Assertion macros used by the checker file of the bilinear 2x upscaler.
`ifndef BILINEAR_2X_UPSCALER_ASSERT_SVH
`define BILINEAR_2X_UPSCALER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BL2X_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BL2X_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bl2x_pkg.sv =====
// Package with types, constants and the byte average of the bilinear 2x upscaler.
package bl2x_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_SIZE   = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = COL_W + 1;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int HGT_W      = ROW_W + 1;
    localparam int CFG_W      = 11;
    localparam int PIX_W      = 32;
    localparam int COORD_W    = 11;
    localparam int OUT_DATA_W = 56;

    typedef enum logic {
        REG_MAP_WIDTH  = 1'b0,
        REG_MAP_HEIGHT = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] br;
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
    } t_block;

    typedef struct packed {
        logic push;
        logic full;
    } t_queue_ctl;

    function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        avg4 = (a | b) - (((a ^ b) >> 1) & 32'h7F7F_7F7F);
    endfunction

endpackage

// ===== sv/bl2x_front.sv =====
// Front part: accepts source pixels, tracks position, keeps the line store and builds blocks.
module bl2x_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [bl2x_pkg::CFG_W-1:0] i_map_width,
    input  logic [bl2x_pkg::CFG_W-1:0] i_map_height,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [bl2x_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_frame_start,
    input  logic                      i_q_full,
    output bl2x_pkg::t_queue_ctl      o_qctl,
    output bl2x_pkg::t_block          o_block
);
    import bl2x_pkg::*;

    logic [PIX_W-1:0] r_mem [MAX_WIDTH];

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_up;
    logic [PIX_W-1:0] r_pix;
    logic [COL_W-1:0] r_x;
    logic [ROW_W-1:0] r_y;
    logic             r_emit;
    logic             r_valid, n_valid;
    logic [PIX_W-1:0] r_left, r_ul;

    logic [WID_W-1:0] w_eff, span, c_inc;
    logic [HGT_W-1:0] h_eff, r_inc;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W-1:0] rw_cur;
    logic             acc, go, emit;
    logic [PIX_W-1:0] tr;

    always_comb begin
        if ({21'd0, i_map_width} < 32'(MIN_SIZE)) begin
            w_eff = WID_W'(MIN_SIZE);
        end else if ({21'd0, i_map_width} > 32'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(i_map_width);
        end
        if ({21'd0, i_map_height} < 32'(MIN_SIZE)) begin
            h_eff = HGT_W'(MIN_SIZE);
        end else if ({21'd0, i_map_height} > 32'(MAX_HEIGHT)) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end else begin
            h_eff = HGT_W'(i_map_height);
        end
        span   = (w_eff - WID_W'(4)) & ~WID_W'(3);
        c_cur  = i_frame_start ? '0 : r_col;
        rw_cur = i_frame_start ? '0 : r_row;
        c_inc  = {1'b0, c_cur} + WID_W'(1);
        r_inc  = {1'b0, rw_cur} + HGT_W'(1);
        emit   = (c_cur != '0) && (rw_cur != '0)
              && ({1'b0, c_cur - COL_W'(1)} < span)
              && ({1'b0, rw_cur - ROW_W'(1)} < (h_eff - HGT_W'(4)));
        if (c_inc >= w_eff) begin
            n_col = '0;
            n_row = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            n_col = c_inc[COL_W-1:0];
            n_row = rw_cur;
        end
    end

    assign go      = r_valid && (!r_emit || !i_q_full);
    assign o_ready = !r_valid || go;
    assign acc     = i_valid && o_ready;
    assign n_valid = acc ? 1'b1 : (go ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_up       <= r_mem[c_cur];
            r_mem[c_cur] <= i_pixel;
            r_pix      <= i_pixel;
            r_x        <= c_cur - COL_W'(1);
            r_y        <= rw_cur - ROW_W'(1);
            r_emit     <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
            r_left  <= '0;
            r_ul    <= '0;
        end else begin
            r_valid <= n_valid;
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (go) begin
                r_left <= r_pix;
                r_ul   <= r_up;
            end
        end
    end

    assign tr          = avg4(r_ul, r_up);
    assign o_block.tl  = r_ul;
    assign o_block.tr  = tr;
    assign o_block.bl  = avg4(r_ul, r_left);
    assign o_block.br  = avg4(tr, avg4(r_left, r_pix));
    assign o_block.x   = r_x;
    assign o_block.y   = r_y;
    assign o_qctl.push = r_valid && r_emit && !i_q_full;
    assign o_qctl.full = i_q_full;
endmodule

// ===== sv/bl2x_queue.sv =====
// Two-entry queue of finished blocks between the front and back parts.
module bl2x_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bl2x_pkg::t_queue_ctl i_qctl,
    input  bl2x_pkg::t_block     i_block,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_pop,
    output bl2x_pkg::t_block     o_head
);
    import bl2x_pkg::*;

    t_block     r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign push    = i_qctl.push && !i_qctl.full;
    assign pop     = i_pop && (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= i_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== sv/bl2x_back.sv =====
// Back part: sends the four pixels of each queued block in order TL, TR, BL, BR.
module bl2x_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  bl2x_pkg::t_block                i_head,
    output logic                            o_pop,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [bl2x_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic                            o_tlast
);
    import bl2x_pkg::*;

    logic [1:0]         r_phase;
    logic               fire;
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] ox, oy;

    assign fire     = i_valid && i_tready;
    assign o_pop    = fire && (r_phase == 2'd3);
    assign o_tvalid = i_valid;
    assign o_tlast  = (r_phase == 2'd3);

    always_comb begin
        case (r_phase)
            2'd0:    pix = i_head.tl;
            2'd1:    pix = i_head.tr;
            2'd2:    pix = i_head.bl;
            default: pix = i_head.br;
        endcase
        ox = COORD_W'({i_head.x, r_phase[0]});
        oy = COORD_W'({i_head.y, r_phase[1]});
    end

    assign o_tdata = {2'b00, oy, ox, pix};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else if (fire) begin
            r_phase <= r_phase + 2'd1;
        end
    end
endmodule

// ===== sv/bilinear_2x_upscaler.sv =====
// Top level of the bilinear 2x upscaler: configuration registers and the three parts.
//
// Channel  Direction  tdata                                  tuser        tlast
// s_axis   in         pixel[31:0]                            frame_start  -
// m_axis   out        out_pixel[31:0] out_x[42:32] out_y[53:43] -          last
// cfg      in         index i_cfg_index, data i_cfg_wdata    -            -
//
// Each source pixel that lies inside the upscaled area yields four output items, one per cycle while
// m_axis_tready is high, so the output channel sets the pace for such pixels; others yield no items.
// A block passes from its source pixel to the output through the line store read, then the queue.
// Reset is synchronous and active low; it clears the counters, the neighbor pixels and queue.
// The front part takes new pixels while the back part drains; it stalls only on a full queue.
module bilinear_2x_upscaler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_index,
    input  logic [bl2x_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bl2x_pkg::PIX_W-1:0]      s_axis_tdata,  // pixel
    input  logic                            s_axis_tuser,  // frame_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bl2x_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // out_pixel, out_x, out_y, zero pad
    output logic                            m_axis_tlast   // last
);
    import bl2x_pkg::*;

    logic [CFG_W-1:0] r_map_width, r_map_height;
    t_queue_ctl       qctl;
    t_block           blk, head;
    logic             q_full, q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= CFG_W'(320);
            r_map_height <= CFG_W'(240);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_MAP_WIDTH:  r_map_width  <= i_cfg_wdata;
                REG_MAP_HEIGHT: r_map_height <= i_cfg_wdata;
                default:        r_map_width  <= r_map_width;
            endcase
        end
    end

    bl2x_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_map_width   (r_map_width),
        .i_map_height  (r_map_height),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_pixel       (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_q_full      (q_full),
        .o_qctl        (qctl),
        .o_block       (blk)
    );

    bl2x_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qctl  (qctl),
        .i_block (blk),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_head  (head)
    );

    bl2x_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_head   (head),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );
endmodule

// ===== sv/bl2x_checker.sv =====
// Port-level checker of the bilinear 2x upscaler and its bind to the top level.
`include "bilinear_2x_upscaler_assert.svh"

module bl2x_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bl2x_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);
    logic out_stall, out_fire, odd_xy;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign odd_xy    = m_axis_tdata[32] && m_axis_tdata[43];

    `BL2X_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "Stalled output item changed.")
    `BL2X_ASSERT_NOW(a_last_odd, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, odd_xy,
        "Last item of a block is not at odd column and odd row.")
    `BL2X_ASSERT_NOW(a_inner_not_br, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, !odd_xy,
        "Bottom-right item not marked last.")
    `BL2X_ASSERT_NEXT(a_block_continues, i_clk, i_rst_n, out_fire && !m_axis_tlast,
        m_axis_tvalid, "Block broken off before its last item.")
    `BL2X_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[55:54] == 2'b00, "Output padding bits are not zero.")
endmodule

bind bilinear_2x_upscaler bl2x_checker u_bl2x_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
